[rtl/dmv_pkg.sv]
// Shared types and constants for the dual-motor velocity loop.
// No dependencies; every other file imports this package.
package dmv_pkg;

  localparam int CountW = 32;
  localparam int CmdW   = 16;
  localparam int DutyW  = 16;
  localparam int GoalW  = 24;
  localparam int GainW  = 16;
  localparam int LimW   = 15;
  localparam int IdleW  = 16;
  localparam int ScaleW = 8;
  localparam int AddrW  = 5;
  localparam int DataW  = 32;

  localparam logic signed [DutyW-1:0] DutyOne = 16'sd16384;

  localparam logic [LimW-1:0]   MaxStepRst  = 15'd16384;
  localparam logic [IdleW-1:0]  TimeoutRst  = 16'd10;
  localparam logic [ScaleW-1:0] ScaleRst    = 8'd1;

  typedef enum logic [0:0] {
    REQ_TICK = 1'b0,
    REQ_CMD  = 1'b1
  } req_type_e;

  typedef enum logic [2:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_MIN_DUTY      = 3'd1,
    REG_MAX_STEP      = 3'd2,
    REG_TIMEOUT_TICKS = 3'd3,
    REG_LEFT_SCALE    = 3'd4,
    REG_RIGHT_SCALE   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    req_type_e               req_type;
    logic signed [CountW-1:0] left_count;
    logic signed [CountW-1:0] right_count;
    logic signed [CmdW-1:0]   left_cmd;
    logic signed [CmdW-1:0]   right_cmd;
  } req_t;

  typedef struct packed {
    logic signed [DutyW-1:0] left_duty;
    logic signed [DutyW-1:0] right_duty;
    logic signed [DutyW-1:0] left_delta;
    logic signed [DutyW-1:0] right_delta;
    logic                    timed_out;
  } rsp_t;

  typedef struct packed {
    logic [GainW-1:0]         prop_gain;
    logic [LimW-1:0]          min_duty;
    logic [LimW-1:0]          max_step;
    logic [IdleW-1:0]         timeout_ticks;
    logic signed [ScaleW-1:0] left_scale;
    logic signed [ScaleW-1:0] right_scale;
  } cfg_t;

endpackage

[rtl/dual_motor_velocity_p_loop_top.sv]
// Top level of the dual-motor proportional velocity loop.
// Depends on dmv_pkg, dmv_apb_regs and dmv_motor_calc.
//
//   channel | direction | handshake               | beat
//   --------+-----------+-------------------------+-----------------------
//   in      | input     | in_valid_i / in_ready_o | req_t: tick or command
//   out     | output    | out_valid_o/out_ready_i | rsp_t: duties, deltas
//   cfg     | input     | APB psel/penable/pwrite | one 32-bit register
//
// An accepted beat lands in the input register; from there the whole update
// runs through one 17x25 multiplier per motor and the result is written to
// the output register. One beat is taken every cycle unless a stalled output
// blocks a tick. Reset restores the register defaults and clears all loop
// state. A stalled output holds its beat and blocks only ticks that
// produce a result; commands and the baseline tick still drain.
module dual_motor_velocity_p_loop_top
  import dmv_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  req_t             in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rsp_t             out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cfg_t cfg;

  dmv_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input register
  req_t req_q;
  logic in_v_q;

  // loop state
  logic signed [CountW-1:0] lprev_q, rprev_q;
  logic signed [DutyW-1:0]  ldrive_q, rdrive_q;
  logic signed [GoalW-1:0]  lgoal_q, rgoal_q;
  logic [IdleW-1:0]         idle_q;
  logic                     tmo_q;
  logic                     base_q;

  // output register
  rsp_t rsp_q;
  logic out_v_q;

  logic                    is_cmd;
  logic                    emits;
  logic                    out_free;
  logic                    fire;
  logic [IdleW-1:0]        idle_inc;
  logic                    tmo_hit;
  logic signed [GoalW-1:0] lgoal_use, rgoal_use;
  logic signed [GoalW-1:0] lgoal_cmd, rgoal_cmd;
  logic signed [DutyW-1:0] ldrive_new, rdrive_new;
  logic signed [DutyW-1:0] ldelta, rdelta;

  assign is_cmd   = (req_q.req_type == REQ_CMD);
  assign emits    = !is_cmd && base_q;
  assign out_free = !out_v_q || out_ready_i;
  // advance the held beat unless it makes a result with nowhere to go
  assign fire     = in_v_q && (out_free || !emits);

  assign in_ready_o  = !in_v_q || fire;
  assign out_valid_o = out_v_q;
  assign out_data_o  = rsp_q;

  // saturating idle count and timeout check for this tick
  assign idle_inc  = (idle_q == '1) ? idle_q : idle_q + 1'b1;
  assign tmo_hit   = (idle_inc >= cfg.timeout_ticks);
  assign lgoal_use = tmo_hit ? '0 : lgoal_q;
  assign rgoal_use = tmo_hit ? '0 : rgoal_q;

  assign lgoal_cmd = GoalW'(req_q.left_cmd) * GoalW'(cfg.left_scale);
  assign rgoal_cmd = GoalW'(req_q.right_cmd) * GoalW'(cfg.right_scale);

  dmv_motor_calc u_left (
    .count_i (req_q.left_count),
    .prev_i  (lprev_q),
    .drive_i (ldrive_q),
    .goal_i  (lgoal_use),
    .cfg_i   (cfg),
    .drive_o (ldrive_new),
    .delta_o (ldelta)
  );

  dmv_motor_calc u_right (
    .count_i (req_q.right_count),
    .prev_i  (rprev_q),
    .drive_i (rdrive_q),
    .goal_i  (rgoal_use),
    .cfg_i   (cfg),
    .drive_o (rdrive_new),
    .delta_o (rdelta)
  );

  // input register: load on accept, drop when the beat advances
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_v_q <= 1'b1;
    end else if (fire) begin
      in_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_data_i;
    end
  end

  // loop state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lprev_q  <= '0;
      rprev_q  <= '0;
      ldrive_q <= '0;
      rdrive_q <= '0;
      lgoal_q  <= '0;
      rgoal_q  <= '0;
      idle_q   <= '0;
      tmo_q    <= 1'b0;
      base_q   <= 1'b0;
    end else if (fire) begin
      if (is_cmd) begin
        lgoal_q <= lgoal_cmd;
        rgoal_q <= rgoal_cmd;
        idle_q  <= '0;
        tmo_q   <= 1'b0;
      end else if (!base_q) begin
        // first tick only records the count baseline
        lprev_q <= req_q.left_count;
        rprev_q <= req_q.right_count;
        base_q  <= 1'b1;
      end else begin
        lprev_q  <= req_q.left_count;
        rprev_q  <= req_q.right_count;
        ldrive_q <= ldrive_new;
        rdrive_q <= rdrive_new;
        idle_q   <= idle_inc;
        if (tmo_hit) begin
          lgoal_q <= '0;
          rgoal_q <= '0;
          tmo_q   <= 1'b1;
        end
      end
    end
  end

  // output register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (fire && emits) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emits) begin
      rsp_q.left_duty   <= ldrive_new;
      rsp_q.right_duty  <= rdrive_new;
      rsp_q.left_delta  <= ldelta;
      rsp_q.right_delta <= rdelta;
      rsp_q.timed_out   <= tmo_q || tmo_hit;
    end
  end

`ifndef SYNTHESIS
  // a result never appears before the count baseline exists
  a_no_result_before_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(base_q))
    else $error("result produced before baseline tick");

  // held duties stay within plus or minus one
  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ldrive_q <= DutyOne) && (ldrive_q >= -DutyOne) &&
    (rdrive_q <= DutyOne) && (rdrive_q >= -DutyOne))
    else $error("held duty out of range");

  // a command clears the idle count and the timeout flag
  a_cmd_clears_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && is_cmd) |=> (idle_q == '0) && !tmo_q)
    else $error("command did not clear idle state");

  // a zero goal forces the emitted duty to zero
  a_zero_goal_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && emits && (lgoal_use == '0)) |=> (rsp_q.left_duty == '0))
    else $error("zero goal gave nonzero duty");
`endif

endmodule

[rtl/dmv_apb_regs.sv]
// APB register bank for the velocity loop settings.
// Depends on dmv_pkg for the register map and the cfg_t bundle.
module dmv_apb_regs
  import dmv_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain     <= '0;
      cfg_q.min_duty      <= '0;
      cfg_q.max_step      <= MaxStepRst;
      cfg_q.timeout_ticks <= TimeoutRst;
      cfg_q.left_scale    <= ScaleRst;
      cfg_q.right_scale   <= ScaleRst;
    end else if (wr_en) begin
      case (idx)
        REG_PROP_GAIN:     cfg_q.prop_gain     <= pwdata[GainW-1:0];
        REG_MIN_DUTY:      cfg_q.min_duty      <= pwdata[LimW-1:0];
        REG_MAX_STEP:      cfg_q.max_step      <= pwdata[LimW-1:0];
        REG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= pwdata[IdleW-1:0];
        REG_LEFT_SCALE:    cfg_q.left_scale    <= pwdata[ScaleW-1:0];
        REG_RIGHT_SCALE:   cfg_q.right_scale   <= pwdata[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PROP_GAIN:     prdata = DataW'(cfg_q.prop_gain);
      REG_MIN_DUTY:      prdata = DataW'(cfg_q.min_duty);
      REG_MAX_STEP:      prdata = DataW'(cfg_q.max_step);
      REG_TIMEOUT_TICKS: prdata = DataW'(cfg_q.timeout_ticks);
      REG_LEFT_SCALE:    prdata = DataW'(cfg_q.left_scale);
      REG_RIGHT_SCALE:   prdata = DataW'(cfg_q.right_scale);
      default:           prdata = '0;
    endcase
  end

endmodule

[rtl/dmv_motor_calc.sv]
// Per-motor duty update: count change, proportional step, limits.
// Depends on dmv_pkg for widths and the cfg_t bundle.
module dmv_motor_calc
  import dmv_pkg::*;
(
  input  logic signed [CountW-1:0] count_i,
  input  logic signed [CountW-1:0] prev_i,
  input  logic signed [DutyW-1:0]  drive_i,
  input  logic signed [GoalW-1:0]  goal_i,
  input  cfg_t                     cfg_i,
  output logic signed [DutyW-1:0]  drive_o,
  output logic signed [DutyW-1:0]  delta_o
);

  logic signed [CountW-1:0] diff;
  logic signed [DutyW-1:0]  rate;
  logic signed [GoalW:0]    err;
  logic signed [GainW:0]    gain_s;
  logic signed [41:0]       prod;
  logic signed [33:0]       step_raw;
  logic signed [33:0]       max_s;
  logic signed [33:0]       max_n;
  logic signed [DutyW-1:0]  step;
  logic signed [17:0]       nd;
  logic signed [17:0]       mn;
  logic signed [17:0]       lim;

  // wrapped change, saturated to 16 bits
  assign diff = count_i - prev_i;

  always_comb begin
    if (diff > 32'sd32767) begin
      rate = 16'sh7FFF;
    end else if (diff < -32'sd32768) begin
      rate = 16'sh8000;
    end else begin
      rate = diff[DutyW-1:0];
    end
  end

  assign err      = (GoalW+1)'(goal_i) - (GoalW+1)'(rate);
  assign gain_s   = $signed({1'b0, cfg_i.prop_gain});
  assign prod     = gain_s * err;
  // arithmetic shift floors toward minus infinity
  assign step_raw = prod[41:8];
  assign max_s    = $signed(34'(cfg_i.max_step));
  assign max_n    = -max_s;

  always_comb begin
    if (step_raw > max_s) begin
      step = max_s[DutyW-1:0];
    end else if (step_raw < max_n) begin
      step = max_n[DutyW-1:0];
    end else begin
      step = step_raw[DutyW-1:0];
    end
  end

  assign mn  = $signed(18'(cfg_i.min_duty));
  assign lim = 18'(DutyOne);

  always_comb begin
    nd = 18'(drive_i) + 18'(step);
    if (goal_i == '0) begin
      nd = '0;
    end else begin
      // push small magnitudes out to the minimum duty
      if (nd >= 18'sd0 && nd < mn) begin
        nd = mn;
      end else if (nd > -mn && nd <= 18'sd0) begin
        nd = -mn;
      end
      if (nd > lim) begin
        nd = lim;
      end else if (nd < -lim) begin
        nd = -lim;
      end
    end
  end

  assign drive_o = nd[DutyW-1:0];
  assign delta_o = rate;

endmodule
